@@ rtl/core/rbp_pkg.sv @@
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared types, constants and helpers of the recurrent byte predictor step.
// ----------------------------------------------------------------------------
package rbp_pkg;

	localparam int IO_BYTES    = 256;
	localparam int MEM_BYTES   = 256;
	localparam int LAYER_LEN   = IO_BYTES + MEM_BYTES;
	localparam int ROW_LEN     = LAYER_LEN + 1;
	localparam int STORE_DEPTH = LAYER_LEN * ROW_LEN;
	localparam int CELLS       = 64;
	localparam int GROUPS      = LAYER_LEN / CELLS;
	localparam int BANK_DEPTH  = GROUPS * ROW_LEN;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);
	localparam int ACC_W       = 25;
	localparam int SCORE_MUL   = IO_BYTES / 32;
	localparam int SCORE_HIT   = IO_BYTES * 255 / 32;

	localparam logic [1:0] FN_LOAD  = 2'd0;
	localparam logic [1:0] FN_CLEAR = 2'd1;
	localparam logic [1:0] FN_STEP  = 2'd2;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

	// column word moving along the cell chain
	typedef struct packed {
		logic               vld;
		logic               first;
		logic               last;
		logic [BANK_AW-1:0] addr;
		logic [7:0]         x;
	} tok_t;

	// finished output byte moving back toward cell 0
	typedef struct packed {
		logic       vld;
		logic [7:0] val;
	} res_t;

	// divide by 2048 toward zero, clamp to 0..255, fill below top bit
	function automatic logic [7:0] squash(input logic signed [ACC_W-1:0] acc);
		logic [ACC_W-1:0] q;
		logic [7:0]       u;
		q = ACC_W'(acc >>> 11);
		if (acc[ACC_W-1]) begin
			u = 8'd0;
		end else if (q > ACC_W'(255)) begin
			u = 8'hff;
		end else begin
			u = q[7:0];
		end
		u = u | (u >> 4);
		u = u | (u >> 2);
		u = u | (u >> 1);
		return u;
	endfunction

endpackage

@@ rtl/core/rbp_ram.sv @@
// ----------------------------------------------------------------------------
// rbp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/rbp_cell.sv @@
// ----------------------------------------------------------------------------
// rbp_cell
// One MAC cell: owns the weight rows of its lane, accumulates one output row
// per pass and hands the column word and finished bytes to its neighbors.
// ----------------------------------------------------------------------------
module rbp_cell import rbp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tok_t               tok_in,
	output tok_t               tok_out,
	input  logic               wr_en,
	input  logic [BANK_AW-1:0] wr_addr,
	input  logic [7:0]         wr_data,
	input  res_t               res_in,
	output res_t               res_out
);

	tok_t                     tok_q;
	logic [7:0]               w_rd;
	logic signed [16:0]       prod;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	res_t                     res_q;

	rbp_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_wram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (tok_in.addr),
		.rdata (w_rd)
	);

	assign prod = $signed({1'b0, tok_q.x}) * $signed(w_rd);

	// advance the column word one cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			done_q <= 1'b0;
		end else begin
			tok_q  <= tok_in;
			done_q <= tok_q.vld & tok_q.last;
		end
	end

	// accumulate: bias first, then products
	always_ff @(posedge clk) begin
		if (tok_q.vld) begin
			if (tok_q.first) begin
				acc_q <= ACC_W'($signed(w_rd));
			end else begin
				acc_q <= acc_q + ACC_W'(prod);
			end
		end
	end

	// load own byte when done, else pass the upstream byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (done_q) begin
			res_q <= '{vld: 1'b1, val: squash(acc_q)};
		end else begin
			res_q <= res_in;
		end
	end

	assign tok_out = tok_q;
	assign res_out = res_q;

endmodule

@@ rtl/core/recurrent_byte_predictor_step.sv @@
// ----------------------------------------------------------------------------
// recurrent_byte_predictor_step
// One step of a recurrent byte predictor on a chain of 64 MAC cells.
// ----------------------------------------------------------------------------
// A character step streams 8 row groups of 513 columns through the cell
// chain, one column a cycle, then drains the last bytes and forms the score.
// One character step is in flight at a time; the next word is taken once the
// result sits in the output register.
// Reset clears control state and marks all remembered bytes as zero.
module recurrent_byte_predictor_step import rbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [18:0] weight_index, [26:19] weight_value, [34:27] char_in,
	// [42:35] char_expected, [47:43] zero
	input  logic [47:0] s_tdata,
	// [1:0] func
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] predicted_char, [24:8] step_score, [25] hit, [31:26] zero
	output logic [31:0] m_tdata
);

	state_t state_q, state_nx;

	logic [1:0]  func;
	logic [18:0] widx;
	logic [7:0]  wval, chr, expc;
	logic        acc_in;

	logic [9:0]  q0, row, col;
	logic [19:0] rem;
	logic        in_range;
	logic [BANK_AW-1:0] wr_addr;
	logic [CELLS-1:0]   wr_en;

	logic        start, feed_en, load_out, feed_last;
	logic [2:0]  g_q;
	logic [9:0]  c_q;
	logic        cur_q;
	logic [7:0]  char_q, expc_q;

	logic               vld_s1, first_s1, last_s1, mvld_s1;
	logic [BANK_AW-1:0] addr_s1;
	logic [9:0]         c_s1;
	logic [7:0]         mem_rd, x_s1, io_idx;
	logic               mem_live_q;

	tok_t tok [CELLS+1];
	res_t res [CELLS+1];

	logic [9:0]  rcnt_q;
	logic [15:0] sum_q;
	logic [7:0]  best_q, pred_q, expv_q;
	logic        hit;
	logic [16:0] score;
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	// unpack the input word
	assign func   = s_tuser;
	assign widx   = s_tdata[18:0];
	assign wval   = s_tdata[26:19];
	assign chr    = s_tdata[34:27];
	assign expc   = s_tdata[42:35];
	assign acc_in = s_tvalid & s_tready;

	// split weight index into row and column (row*513 + col)
	always_comb begin
		q0       = widx[18:9];
		rem      = {1'b0, widx} - ({1'b0, q0, 9'b0} + {10'b0, q0});
		in_range = widx < 19'(STORE_DEPTH);
		if (rem[19]) begin
			row = q0 - 10'd1;
			col = rem[9:0] + 10'(ROW_LEN);
		end else begin
			row = q0;
			col = rem[9:0];
		end
		wr_addr = BANK_AW'({row[8:6], 9'b0}) + BANK_AW'(row[8:6]) + BANK_AW'(col);
		for (int j = 0; j < CELLS; j++) begin
			wr_en[j] = acc_in && func == FN_LOAD && in_range && row[5:0] == 6'(j);
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (acc_in && func == FN_STEP) state_nx = ST_RUN;
			ST_RUN:   if (feed_last) state_nx = ST_DRAIN;
			ST_DRAIN: if (rcnt_q == 10'(LAYER_LEN)) state_nx = ST_FIN;
			ST_FIN:   if (!m_tvalid_q || m_tready) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready  = state_q == ST_IDLE;
		start     = acc_in && func == FN_STEP;
		feed_en   = state_q == ST_RUN;
		feed_last = g_q == 3'(GROUPS - 1) && c_q == 10'(LAYER_LEN);
		load_out  = state_q == ST_FIN && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// column and group counters of the feeder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q    <= '0;
			c_q    <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= feed_en;
			if (start) begin
				g_q <= '0;
				c_q <= '0;
			end else if (feed_en) begin
				if (c_q == 10'(LAYER_LEN)) begin
					c_q <= '0;
					g_q <= g_q + 3'd1;
				end else begin
					c_q <= c_q + 10'd1;
				end
			end
		end
	end

	// feeder stage payload
	always_ff @(posedge clk) begin
		first_s1 <= c_q == 10'd0;
		last_s1  <= c_q == 10'(LAYER_LEN);
		addr_s1  <= BANK_AW'({g_q, 9'b0}) + BANK_AW'(g_q) + BANK_AW'(c_q);
		c_s1     <= c_q;
		mvld_s1  <= mem_live_q;
		if (start) begin
			char_q <= chr;
			expc_q <= expc;
		end
	end

	// remembered bytes, two banks swapped each step
	rbp_ram #(.WIDTH(8), .DEPTH(2 * MEM_BYTES)) u_mram (
		.clk   (clk),
		.we    (res[0].vld & rcnt_q[8]),
		.waddr ({~cur_q, rcnt_q[7:0]}),
		.wdata (res[0].val),
		.raddr ({cur_q, c_q[7:0] - 8'd1}),
		.rdata (mem_rd)
	);

	// layer byte of the current column
	always_comb begin
		io_idx = 8'(c_s1 - 10'd1);
		if (first_s1) begin
			x_s1 = 8'd0;
		end else if (c_s1 <= 10'(IO_BYTES)) begin
			x_s1 = (io_idx == char_q) ? 8'hff : 8'd0;
		end else begin
			x_s1 = mvld_s1 ? mem_rd : 8'd0;
		end
	end

	assign tok[0] = '{vld: vld_s1, first: first_s1, last: last_s1, addr: addr_s1, x: x_s1};
	assign res[CELLS] = '0;

	// chain of MAC cells
	for (genvar j = 0; j < CELLS; j++) begin : g_cell
		rbp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[j]),
			.tok_out (tok[j+1]),
			.wr_en   (wr_en[j]),
			.wr_addr (wr_addr),
			.wr_data (wval),
			.res_in  (res[j+1]),
			.res_out (res[j])
		);
	end

	// collect finished bytes in row order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q     <= '0;
			cur_q      <= 1'b0;
			mem_live_q <= 1'b0;
		end else begin
			if (start) begin
				rcnt_q <= '0;
			end else if (res[0].vld) begin
				rcnt_q <= rcnt_q + 10'd1;
			end
			// a finished step fills the whole new bank; clear drops it
			if (acc_in && func == FN_CLEAR) begin
				mem_live_q <= 1'b0;
			end else if (load_out) begin
				mem_live_q <= 1'b1;
			end
			if (load_out) begin
				cur_q <= ~cur_q;
			end
		end
	end

	// io byte sum, first max and expected byte
	always_ff @(posedge clk) begin
		if (start) begin
			sum_q  <= '0;
			best_q <= '0;
			pred_q <= '0;
			expv_q <= '0;
		end else if (res[0].vld && !rcnt_q[8]) begin
			sum_q <= sum_q + 16'(res[0].val);
			if (res[0].val > best_q) begin
				best_q <= res[0].val;
				pred_q <= rcnt_q[7:0];
			end
			if (rcnt_q[7:0] == expc_q) begin
				expv_q <= res[0].val;
			end
		end
	end

	// score
	always_comb begin
		hit   = pred_q == expc_q;
		score = 17'(expv_q) * 17'(SCORE_MUL) + (hit ? 17'(SCORE_HIT) : 17'd0)
			- {1'b0, sum_q};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {6'b0, hit, score, pred_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/core/rbp_checker.sv @@
// ----------------------------------------------------------------------------
// rbp_checker
// Port-level checks of the recurrent byte predictor step.
// ----------------------------------------------------------------------------
module rbp_checker import rbp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [47:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// pad bits of a result stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:26] == 6'b0)
		else $error("result pad bits set");

	// a character step blocks the input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == FN_STEP |=> !s_tready)
		else $error("input taken during a character step");

	// weight load and clear leave the input ready in the next cycle
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == FN_LOAD || s_tuser == FN_CLEAR)
		|=> s_tready)
		else $error("short command held the input");

endmodule

bind recurrent_byte_predictor_step rbp_checker u_rbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream-level test of recurrent_byte_predictor_step: loads every weight,
// then runs directed, back-pressure and random words against a behavioral
// predictor of the layer, checking each result word field by field.
// ----------------------------------------------------------------------------
module tb import rbp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 60000;
	localparam int DRAIN_CYCLES   = 400;
	localparam int RANDOM_WORDS   = 140;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	// behavioral copy of the block state
	logic signed [7:0] layer_weights [STORE_DEPTH];
	logic [7:0]        recall_bytes [MEM_BYTES];
	logic [31:0]       pending_results [$];

	int  mismatches = 0;
	int  stall_cycles = 0;
	int  hold_cycles = 0;
	bit  idle_on = 1'b0;

	recurrent_byte_predictor_step i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// divide toward zero, clamp, fill below the top bit
	function automatic logic [7:0] squash_sum(longint acc);
		longint v;
		logic [7:0] u;
		v = acc / 2048;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		u = v[7:0];
		u = u | (u >> 4);
		u = u | (u >> 2);
		u = u | (u >> 1);
		return u;
	endfunction

	// one character step: update remembered bytes and form the result word
	function automatic logic [31:0] predict_char_step(logic [7:0] ch, logic [7:0] expc);
		logic [7:0] outs [LAYER_LEN];
		longint acc;
		int base;
		logic [7:0] best;
		logic [7:0] pred;
		longint score;
		logic hit;
		logic [16:0] score17;
		best = 8'd0;
		pred = 8'd0;
		score = 0;
		for (int r = 0; r < LAYER_LEN; r++) begin
			base = r * ROW_LEN;
			acc = layer_weights[base];
			// only one io byte is nonzero
			acc += 255 * longint'(layer_weights[base + 1 + ch]);
			for (int s = 0; s < MEM_BYTES; s++)
				acc += longint'(recall_bytes[s]) * longint'(layer_weights[base + 1 + IO_BYTES + s]);
			outs[r] = squash_sum(acc);
		end
		for (int s = 0; s < MEM_BYTES; s++) recall_bytes[s] = outs[IO_BYTES + s];
		for (int s = 0; s < IO_BYTES; s++) begin
			if (outs[s] > best) begin
				best = outs[s];
				pred = s[7:0];
			end
			score -= outs[s];
		end
		hit = (pred == expc);
		score += longint'(outs[expc]) * SCORE_MUL;
		if (hit) score += SCORE_HIT;
		score17 = score[16:0];
		return {6'd0, hit, score17, pred};
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// send one word, idling first at random, and predict on acceptance
	task automatic send_word(logic [1:0] fn, logic [18:0] idx, logic [7:0] wval,
			logic [7:0] ch, logic [7:0] expc);
		@(negedge clk);
		if (idle_on && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {5'd0, expc, ch, wval, idx};
		do @(posedge clk); while (!s_tready);
		case (fn)
			FN_LOAD: if (idx < STORE_DEPTH) layer_weights[idx] = wval;
			FN_CLEAR: foreach (recall_bytes[i]) recall_bytes[i] = 8'd0;
			FN_STEP: pending_results.push_back(predict_char_step(ch, expc));
			default: ;
		endcase
	endtask

	task automatic release_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_results();
		release_input();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic random_load();
		logic [18:0] idx;
		idx = ($urandom_range(9) == 0) ? 19'($urandom) : 19'($urandom_range(STORE_DEPTH - 1));
		send_word(FN_LOAD, idx, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic random_step();
		send_word(FN_STEP, 19'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// fill the whole store; no step may read an unwritten weight
	task automatic test_load_all();
		for (int i = 0; i < STORE_DEPTH; i++)
			send_word(FN_LOAD, 19'(i), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_directed();
		send_word(FN_STEP, 19'd0, 8'd0, 8'd0, 8'd0);
		send_word(FN_STEP, 19'h7ffff, 8'hff, 8'd255, 8'd255);
		send_word(FN_LOAD, 19'(STORE_DEPTH - 1), 8'h80, 8'd0, 8'd0);
		send_word(FN_LOAD, 19'd0, 8'h7f, 8'hff, 8'hff);
		// writes past the store are dropped
		send_word(FN_LOAD, 19'h7ffff, 8'h7f, 8'd0, 8'd0);
		send_word(FN_LOAD, 19'(STORE_DEPTH), 8'h80, 8'd0, 8'd0);
		send_word(FN_STEP, 19'd0, 8'd0, 8'd7, 8'd7);
		// unused selector does nothing
		send_word(2'd3, 19'h7ffff, 8'hff, 8'hff, 8'hff);
		send_word(FN_CLEAR, 19'h2aaaa, 8'h55, 8'haa, 8'h55);
		send_word(FN_STEP, 19'h55555, 8'haa, 8'h55, 8'haa);
		send_word(FN_STEP, 19'd0, 8'd0, 8'd128, 8'd0);
		// aim a step at the just-predicted character to reach a hit
		send_word(FN_STEP, 19'd0, 8'd0, 8'd0, pending_results[$][7:0]);
		send_word(FN_STEP, 19'd0, 8'd0, 8'd1, 8'd254);
		wait_results();
	endtask

	// receiver holds off while the sender keeps offering steps and a weight load
	task automatic test_backpressure();
		hold_cycles = 12000;
		repeat (4) random_step();
		send_word(FN_LOAD, 19'd513, 8'h7f, 8'd0, 8'd0);
		random_step();
		wait_results();
	endtask

	task automatic test_random();
		int pick;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(99);
			if (pick < 45) random_step();
			else if (pick < 80) random_load();
			else if (pick < 92) send_word(FN_CLEAR, 19'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
			else if (pick < 97) send_word(2'd3, 19'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
			else wait_results();
		end
		wait_results();
	endtask

	// drive result ready: hold-off first, else random idling
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= !(idle_on && $urandom_range(99) < 37);
		end
	end

	// check each result word and watch for a stuck block
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", m_tdata, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[7:0] != want[7:0])
					report_mismatch("predicted_char", 32'(m_tdata[7:0]), 32'(want[7:0]));
				if (m_tdata[24:8] != want[24:8])
					report_mismatch("step_score", 32'(m_tdata[24:8]), 32'(want[24:8]));
				if (m_tdata[25] != want[25])
					report_mismatch("hit", 32'(m_tdata[25]), 32'(want[25]));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		foreach (layer_weights[i]) layer_weights[i] = 8'sd0;
		foreach (recall_bytes[i]) recall_bytes[i] = 8'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_load_all();
		idle_on = 1'b1;
		test_directed();
		test_backpressure();
		test_random();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/rbp_pkg.sv
rtl/core/rbp_ram.sv
rtl/core/rbp_cell.sv
rtl/core/recurrent_byte_predictor_step.sv
rtl/core/rbp_checker.sv
test/tb.sv
